[hdl/cstp_pkg.sv]
package cstp_pkg;

   localparam int FUNC_COUNT  = 256;
   localparam int FUNC_BITS   = 8;
   localparam int STACK_DEPTH = 64;
   localparam int STACK_BITS  = 6;
   localparam int DEPTH_BITS  = 7;
   localparam int TIME_BITS   = 48;
   localparam int COUNT_BITS  = 32;
   localparam int SKIP_BITS   = 16;

   typedef enum logic [2:0] {
      OP_ENTER = 3'd0,
      OP_LEAVE = 3'd1,
      OP_READ  = 3'd2,
      OP_CLEAR = 3'd3,
      OP_START = 3'd4,
      OP_STOP  = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]           operation;
      logic [FUNC_BITS-1:0] func_index;
      logic [TIME_BITS-1:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  entry_all_time;
      logic [TIME_BITS-1:0]  entry_self_time;
      logic [COUNT_BITS-1:0] entry_call_count;
      logic [DEPTH_BITS-1:0] depth_now;
      logic                  slow_call;
      logic                  running;
      logic                  stack_overflowed;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request, start memory reads
      logic exec;       // apply the operation with read data in hand
      logic clr_step;   // clear one table row
      logic clr_start;  // reset the clear address
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_clear;
      logic clr_last;
   } sts_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction

endpackage

[hdl/cstp_ctrl.sv]
module cstp_ctrl
   import cstp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);

   typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC, S_CLEAR} state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
               busy_in  = 1'b1;
            end
         end
         S_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.clr_start = 1'b1;
            valid_in      = 1'b1;
            if (sts.need_clear) begin
               state_in = S_CLEAR;
            end else begin
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

[hdl/cstp_datapath.sv]
module cstp_datapath
   import cstp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  req_type              req_data,
   input  logic                 csr_write,
   input  logic [TIME_BITS-1:0] csr_data,
   output sts_type              sts,
   output rsp_type              rsp_data
);

   // Stack and table memories.
   logic [FUNC_BITS-1:0]  fid_mem   [STACK_DEPTH];
   logic [TIME_BITS-1:0]  fst_mem   [STACK_DEPTH];
   logic [TIME_BITS-1:0]  fcl_mem   [STACK_DEPTH];
   logic [TIME_BITS-1:0]  inc_mem   [FUNC_COUNT];
   logic [TIME_BITS-1:0]  exc_mem   [FUNC_COUNT];
   logic [COUNT_BITS-1:0] cnt_mem   [FUNC_COUNT];

   logic [TIME_BITS-1:0]  thr_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic [SKIP_BITS-1:0]  skip_ff;
   logic                  active_ff, stop_ff;
   logic [FUNC_BITS-1:0]  clr_addr_ff;
   req_type               req_ff;
   rsp_type               rsp_ff;

   // Function id of the top frame, kept in a register so that it can address the tables.
   logic [FUNC_BITS-1:0]  top_fid_ff;

   // Read data registered at load.
   logic [FUNC_BITS-1:0]  par_id_ff;
   logic [TIME_BITS-1:0]  top_st_ff, top_cl_ff, par_cl_ff;
   logic [TIME_BITS-1:0]  r_inc_ff, r_exc_ff;
   logic [COUNT_BITS-1:0] r_cnt_ff;
   logic [TIME_BITS-1:0]  t_inc_ff, t_exc_ff;

   logic [DEPTH_BITS-1:0] dm1, dm2;
   assign dm1 = depth_ff - DEPTH_BITS'(1);
   assign dm2 = depth_ff - 7'd2;

   // Load: read the stack top, its parent and the table rows.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         top_st_ff <= fst_mem[dm1[STACK_BITS-1:0]];
         top_cl_ff <= fcl_mem[dm1[STACK_BITS-1:0]];
         par_cl_ff <= fcl_mem[dm2[STACK_BITS-1:0]];
         par_id_ff <= fid_mem[dm2[STACK_BITS-1:0]];
         r_inc_ff  <= inc_mem[req_data.func_index];
         r_exc_ff  <= exc_mem[req_data.func_index];
         r_cnt_ff  <= cnt_mem[req_data.func_index];
         t_inc_ff  <= inc_mem[top_fid_ff];
         t_exc_ff  <= exc_mem[top_fid_ff];
      end
   end

   // Execute arithmetic.
   logic [TIME_BITS-1:0] delta, self_t, new_inc;
   logic                 is_enter, is_leave, absorb, do_pop, full, outer;
   logic [FUNC_BITS-1:0] push_id;
   assign is_enter = req_ff.operation == OP_ENTER && active_ff;
   assign is_leave = req_ff.operation == OP_LEAVE && active_ff;
   assign absorb   = is_leave && skip_ff != '0;
   assign do_pop   = is_leave && !absorb && depth_ff != '0;
   assign full     = depth_ff >= DEPTH_BITS'(STACK_DEPTH);
   assign outer    = do_pop && depth_ff == DEPTH_BITS'(1);
   assign delta    = req_ff.timestamp - top_st_ff;
   assign self_t   = top_cl_ff > delta ? '0 : delta - top_cl_ff;
   assign new_inc  = sat_add(t_inc_ff, delta);
   assign push_id  = (req_ff.func_index == '0 && depth_ff != '0) ? top_fid_ff
                                                                : req_ff.func_index;

   // Memory writes.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         inc_mem[clr_addr_ff] <= '0;
         exc_mem[clr_addr_ff] <= '0;
         cnt_mem[clr_addr_ff] <= '0;
      end else if (cmd.exec) begin
         if (is_enter) begin
            if (r_cnt_ff != '1) cnt_mem[req_ff.func_index] <= r_cnt_ff + COUNT_BITS'(1);
            if (!full) begin
               fid_mem[depth_ff[STACK_BITS-1:0]] <= push_id;
               fst_mem[depth_ff[STACK_BITS-1:0]] <= req_ff.timestamp;
               fcl_mem[depth_ff[STACK_BITS-1:0]] <= '0;
            end
         end
         if (do_pop) begin
            inc_mem[top_fid_ff] <= new_inc;
            exc_mem[top_fid_ff] <= sat_add(t_exc_ff, self_t);
            if (!outer) fcl_mem[dm2[STACK_BITS-1:0]] <= sat_add(par_cl_ff, delta);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0; depth_ff <= '0; skip_ff <= '0;
         active_ff <= 1'b0; stop_ff <= 1'b0;
         clr_addr_ff <= '0; top_fid_ff <= '0;
      end else begin
         if (csr_write) thr_ff <= csr_data;
         if (cmd.clr_start) clr_addr_ff <= '0;
         else if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + FUNC_BITS'(1);
         if (cmd.exec) begin
            if (is_enter) begin
               if (full) begin
                  if (skip_ff != '1) skip_ff <= skip_ff + SKIP_BITS'(1);
               end else begin
                  depth_ff   <= depth_ff + DEPTH_BITS'(1);
                  top_fid_ff <= push_id;
               end
            end
            if (absorb) skip_ff <= skip_ff - SKIP_BITS'(1);
            if (do_pop) begin
               depth_ff   <= depth_ff - DEPTH_BITS'(1);
               top_fid_ff <= outer ? '0 : par_id_ff;
            end
            if (outer && stop_ff) begin
               active_ff <= 1'b0; stop_ff <= 1'b0;
            end
            if (req_ff.operation == OP_START) begin
               active_ff <= 1'b1; stop_ff <= 1'b0;
            end
            if (req_ff.operation == OP_STOP) stop_ff <= 1'b1;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.entry_all_time   <= req_ff.operation == OP_READ ? r_inc_ff : '0;
         rsp_ff.entry_self_time  <= req_ff.operation == OP_READ ? r_exc_ff : '0;
         rsp_ff.entry_call_count <= req_ff.operation == OP_READ ? r_cnt_ff : '0;
         rsp_ff.depth_now        <= (is_enter && !full) ? depth_ff + DEPTH_BITS'(1)
                                    : do_pop ? depth_ff - DEPTH_BITS'(1) : depth_ff;
         rsp_ff.slow_call        <= outer && thr_ff != '0 && new_inc > thr_ff;
         rsp_ff.running          <= req_ff.operation == OP_START ? 1'b1
                                    : (outer && stop_ff) ? 1'b0 : active_ff;
         rsp_ff.stack_overflowed <= is_enter && full;
      end
   end

   // The controller looks at this while executing, so it is decided from the loaded item.
   assign sts.need_clear = (req_ff.operation == OP_CLEAR && active_ff)
                           || (outer && thr_ff != '0);
   assign sts.clr_last   = clr_addr_ff == '1;
   assign rsp_data       = rsp_ff;

endmodule

[hdl/call_stack_time_profiler.sv]
// Channel | Ports                          | Handshake
// request | req_data                       | start high, busy low
// result  | rsp_data                       | rsp_valid, one cycle
// config  | csr_write, csr_data            | csr_write, no wait
// An item goes through load with memory reads, then execute. A clear
// while active, or an outermost leave with nonzero threshold, adds a
// clearing pass over all 256 table rows, one row a cycle; after reset
// one runs with busy high. The receiver cannot stall; results are strobed.
module call_stack_time_profiler
   import cstp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [TIME_BITS-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   cstp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   cstp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data),
      .csr_write(csr_write), .csr_data(csr_data), .sts(sts), .rsp_data(rsp_data)
   );

   // A transfer is followed by a result, through the execute state and the registered rsp_valid.
   a_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid) else $error("missing result");

   // A result only comes when busy was high before it.
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("spurious result");

endmodule
